// ----- rtl/core/tcu_pkg.sv -----
// ============================================================================
// TCP Tahoe congestion window update: shared package
// Beat types, event codes and reset constants for the window update block.
// ============================================================================
`default_nettype none

package tcu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MSS_W  = 16;

    localparam logic [1:0] CMD_NEW_ACK = 2'd0;
    localparam logic [1:0] CMD_DUP_ACK = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [7:0]        DUP_TRIGGER = 8'd3;
    localparam logic [MSS_W-1:0]  MSS_RESET   = 16'd536;
    localparam logic [WORD_W-1:0] WORD_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        dup_ack_count;
        logic [WORD_W-1:0] peer_window;
        logic              timeout_abort;
    } tcu_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] cong_window;
        logic [WORD_W-1:0] slow_start_limit;
        logic              retransmit_one;
        logic              restart_timer;
        logic              try_send;
    } tcu_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcp_tahoe_cwnd_update_top.sv -----
// ============================================================================
// TCP Tahoe congestion window update
// Keeps cwnd and ssthresh for one sender and updates them once per event.
// ============================================================================
//
//  Channel | Direction | Handshake        | Beat contents
//  --------+-----------+------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | event: cmd, dup count, peer win
//  out     | output    | out_valid/out_stall| new cwnd, ssthresh, three flags
//  cfg     | input     | cfg_valid/cfg_ready| maximum segment size (16 bits)
//
// An event that needs no division goes through the decide step and then the
// output load into the output register. A new-data ACK in congestion
// avoidance goes through the decide step, the mss*mss product, the restoring
// divider (one quotient bit per cycle), the add with saturation and the output
// load, which waits while a previous result is stalled. A new event is taken as
// soon as the sequencer is idle, even while the previous result is stalled.
// Reset sets cwnd to 536, ssthresh to all ones and the MSS register to 536.
`default_nettype none

module tcp_tahoe_cwnd_update_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tcu_pkg::tcu_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tcu_pkg::tcu_out_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);

    import tcu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_ADD,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    tcu_in_t           item_reg, item_next;
    tcu_out_t          res_reg, res_next;
    tcu_out_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [MSS_W-1:0]  mss_reg, mss_next;
    logic [WORD_W-1:0] cwnd_reg, cwnd_next;
    logic [WORD_W-1:0] ssthresh_reg, ssthresh_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [4:0]        cnt_reg, cnt_next;

    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_diff;
    logic [WORD_W-1:0] flight;
    logic [WORD_W-1:0] half;
    logic [WORD_W-1:0] floor2;
    logic [WORD_W-1:0] thresh_loss;
    logic [WORD_W-1:0] incr;
    logic [WORD_W:0]   grow_sum;
    logic [WORD_W-1:0] grow_sat;
    logic [WORD_W:0]   ss_sum;
    logic [WORD_W-1:0] ss_sat;
    logic              out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // One restoring divider step: shift in the next dividend bit, try to subtract.
    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    // Threshold after a loss: max(min(cwnd, peer)/2, 2*mss).
    assign flight      = (cwnd_reg < item_reg.peer_window) ? cwnd_reg : item_reg.peer_window;
    assign half        = {1'b0, flight[WORD_W-1:1]};
    assign floor2      = {{(WORD_W-MSS_W-1){1'b0}}, mss_reg, 1'b0};
    assign thresh_loss = (half > floor2) ? half : floor2;

    assign ss_sum = {1'b0, cwnd_reg} + {{(WORD_W-MSS_W+1){1'b0}}, mss_reg};
    assign ss_sat = ss_sum[WORD_W] ? WORD_MAX : ss_sum[WORD_W-1:0];

    assign incr     = (quo_reg == '0) ? {{(WORD_W-1){1'b0}}, 1'b1} : quo_reg;
    assign grow_sum = {1'b0, cwnd_reg} + {1'b0, incr};
    assign grow_sat = grow_sum[WORD_W] ? WORD_MAX : grow_sum[WORD_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mss_next       = mss_reg;
        cwnd_next      = cwnd_reg;
        ssthresh_next  = ssthresh_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            mss_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                res_next.cong_window      = cwnd_reg;
                res_next.slow_start_limit = ssthresh_reg;
                res_next.retransmit_one   = 1'b0;
                res_next.restart_timer    = 1'b0;
                res_next.try_send         = 1'b0;
                state_next                = S_OUT;
                case (item_reg.cmd)
                    CMD_NEW_ACK:
                    begin
                        res_next.try_send = 1'b1;
                        if (cwnd_reg < ssthresh_reg)
                        begin
                            res_next.cong_window = ss_sat;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    CMD_DUP_ACK:
                    begin
                        if (item_reg.dup_ack_count == DUP_TRIGGER)
                        begin
                            res_next.cong_window      = {{(WORD_W-MSS_W){1'b0}}, mss_reg};
                            res_next.slow_start_limit = thresh_loss;
                            res_next.retransmit_one   = 1'b1;
                            res_next.restart_timer    = 1'b1;
                        end
                    end
                    CMD_TIMEOUT:
                    begin
                        if (!item_reg.timeout_abort)
                        begin
                            res_next.cong_window      = {{(WORD_W-MSS_W){1'b0}}, mss_reg};
                            res_next.slow_start_limit = thresh_loss;
                            res_next.retransmit_one   = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_MUL:
            begin
                quo_next   = {{(WORD_W-MSS_W){1'b0}}, mss_reg}
                             * {{(WORD_W-MSS_W){1'b0}}, mss_reg};
                rem_next   = '0;
                div_next   = (cwnd_reg == '0) ? {{(WORD_W-1){1'b0}}, 1'b1} : cwnd_reg;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (!rem_diff[WORD_W])
                begin
                    rem_next = rem_diff[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                res_next.cong_window = grow_sat;
                state_next           = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    cwnd_next      = res_reg.cong_window;
                    ssthresh_next  = res_reg.slow_start_limit;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            mss_reg       <= MSS_RESET;
            cwnd_reg      <= {{(WORD_W-MSS_W){1'b0}}, MSS_RESET};
            ssthresh_reg  <= WORD_MAX;
            quo_reg       <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            mss_reg       <= mss_next;
            cwnd_reg      <= cwnd_next;
            ssthresh_reg  <= ssthresh_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            div_reg       <= div_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

`default_nettype wire
